// ----- design/bba_pkg.sv -----
package bba_pkg;

	localparam int NUM_BLOCKS_DEF    = 32768;
	localparam int MAP_WORD_BITS_DEF = 64;

	localparam int CFG_W = 16;
	localparam int ID_W  = 15;

	localparam logic [CFG_W-1:0] TOTAL_BLOCKS_RST  = 16'd32768;
	localparam logic [CFG_W-1:0] RESERVE_BELOW_RST = 16'd4096;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef enum logic [0:0] {
		REG_TOTAL_BLOCKS  = 1'b0,
		REG_RESERVE_BELOW = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		FUNC_ALLOC = 1'b0,
		FUNC_FREE  = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_FREE_WR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic rd_next;
		logic scan_adv;
		logic wr_alloc;
		logic wr_free;
		logic wr_clr;
		logic clr_adv;
		logic set_full;
		logic set_hit;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_free;
		logic empty;
		logic hit;
		logic at_last;
		logic in_map;
		logic clr_done;
	} sts_t;

endpackage

// ----- design/bba_ctrl.sv -----
module bba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	input  bba_pkg::sts_t sts,
	output bba_pkg::cmd_t cmd
);

	bba_pkg::state_t state_q;
	bba_pkg::state_t state_nxt;
	logic            rsp_valid_q;

	assign req_stall = (state_q != bba_pkg::ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bba_pkg::ST_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			bba_pkg::ST_CLEAR: begin
				cmd.wr_clr = 1'b1;
				if (sts.clr_done) begin
					state_nxt = bba_pkg::ST_IDLE;
				end else begin
					cmd.clr_adv = 1'b1;
				end
			end
			bba_pkg::ST_IDLE: begin
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = bba_pkg::ST_START;
				end
			end
			bba_pkg::ST_START: begin
				if (sts.is_free) begin
					cmd.rd    = 1'b1;
					state_nxt = bba_pkg::ST_FREE_WR;
				end else if (sts.empty) begin
					cmd.set_full = 1'b1;
					state_nxt    = bba_pkg::ST_DONE;
				end else begin
					cmd.rd    = 1'b1;
					state_nxt = bba_pkg::ST_SCAN;
				end
			end
			bba_pkg::ST_SCAN: begin
				if (sts.hit) begin
					cmd.wr_alloc = 1'b1;
					cmd.set_hit  = 1'b1;
					state_nxt    = bba_pkg::ST_DONE;
				end else if (sts.at_last) begin
					cmd.set_full = 1'b1;
					state_nxt    = bba_pkg::ST_DONE;
				end else begin
					// fetch the next word while this one is checked
					cmd.rd_next  = 1'b1;
					cmd.scan_adv = 1'b1;
				end
			end
			bba_pkg::ST_FREE_WR: begin
				cmd.wr_free = sts.in_map;
				state_nxt   = bba_pkg::ST_DONE;
			end
			bba_pkg::ST_DONE: begin
				// hold until the output register is free
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.out_load = 1'b1;
					state_nxt    = bba_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = bba_pkg::ST_IDLE;
			end
		endcase
	end

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_alloc, cmd.wr_free, cmd.wr_clr}))
		else $error("more than one map write in a cycle");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == bba_pkg::ST_DONE))
		else $error("result raised outside the done state");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == bba_pkg::ST_START))
		else $error("accepted item did not start");

endmodule

// ----- design/bba_datapath.sv -----
module bba_datapath #(
	parameter int NUM_BLOCKS    = bba_pkg::NUM_BLOCKS_DEF,
	parameter int MAP_WORD_BITS = bba_pkg::MAP_WORD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bba_pkg::cmd_t              cmd,
	output bba_pkg::sts_t              sts,
	input  logic                       func,
	input  logic [bba_pkg::ID_W-1:0]   block_id,
	input  logic [bba_pkg::CFG_W-1:0]  total_blocks,
	input  logic [bba_pkg::CFG_W-1:0]  reserve_below,
	output logic [bba_pkg::ID_W-1:0]   alloc_id,
	output logic                       status
);

	// MAP_WORD_BITS must be a power of two; the block itself does not enforce it
	localparam int W     = MAP_WORD_BITS;
	localparam int SH    = $clog2(W);
	localparam int DEPTH = (NUM_BLOCKS + W - 1) / W;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW    = AW + SH;
	localparam int NBW   = $clog2(NUM_BLOCKS + 1);
	localparam int CW    = (NBW > bba_pkg::CFG_W) ? NBW : bba_pkg::CFG_W;
	localparam int BW    = (IW > bba_pkg::ID_W) ? IW : bba_pkg::ID_W;
	localparam logic [CW-1:0] NB_C     = CW'(NUM_BLOCKS);
	localparam logic [AW-1:0] LAST_ROW = AW'(DEPTH - 1);

	logic [W-1:0]  mem [DEPTH];
	logic [W-1:0]  rd_q;
	logic [AW-1:0] scan_q;
	logic [AW-1:0] clr_q;
	logic [CW-1:0] lo_q;
	logic [CW-1:0] hi_q;
	logic          empty_q;
	logic          func_q;
	logic          in_map_q;
	logic [SH-1:0] bit_q;
	logic [bba_pkg::ID_W-1:0] res_id_q;
	logic          res_full_q;

	logic [CW-1:0] total_ext;
	logic [CW-1:0] lo_ext;
	logic [CW-1:0] hi_eff;
	logic [BW-1:0] blk_ext;
	logic [CW-1:0] last_idx;
	logic [AW-1:0] last_word;
	logic [SH-1:0] last_end;
	logic [AW-1:0] lo_word;
	logic [SH-1:0] lo_off;
	logic [W-1:0]  free_vec;
	logic [SH-1:0] pos;
	logic          hit;
	logic [IW-1:0] found;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [W-1:0]  wr_data;

	assign total_ext = CW'(total_blocks);
	assign lo_ext    = CW'(reserve_below);
	assign hi_eff    = (total_ext > NB_C) ? NB_C : total_ext;
	assign blk_ext   = BW'(block_id);

	assign last_idx  = hi_q - CW'(1);
	assign last_word = AW'(last_idx >> SH);
	assign last_end  = last_idx[SH-1:0];
	assign lo_word   = AW'(lo_q >> SH);
	assign lo_off    = lo_q[SH-1:0];

	// clear bits of the current word inside the allocation window
	always_comb begin
		for (int j = 0; j < W; j++) begin
			free_vec[j] = !rd_q[j]
				&& ((scan_q != lo_word) || (SH'(j) >= lo_off))
				&& ((scan_q != last_word) || (SH'(j) <= last_end));
		end
	end

	always_comb begin
		pos = '0;
		for (int j = W - 1; j >= 0; j--) begin
			if (free_vec[j]) begin
				pos = SH'(j);
			end
		end
	end

	assign hit   = |free_vec;
	assign found = {scan_q, pos};

	assign rd_addr = cmd.rd_next ? (scan_q + AW'(1)) : scan_q;

	always_comb begin
		wr_en   = cmd.wr_clr || cmd.wr_alloc || cmd.wr_free;
		wr_addr = scan_q;
		wr_data = rd_q & ~(W'(1) << bit_q);
		if (cmd.wr_clr) begin
			wr_addr = clr_q;
			wr_data = '0;
		end else if (cmd.wr_alloc) begin
			wr_data = rd_q | (W'(1) << pos);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd || cmd.rd_next) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_adv) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q     <= func;
			lo_q       <= lo_ext;
			hi_q       <= hi_eff;
			empty_q    <= (lo_ext >= hi_eff);
			in_map_q   <= (CW'(block_id) < NB_C);
			bit_q      <= blk_ext[SH-1:0];
			res_id_q   <= '0;
			res_full_q <= 1'b0;
			if (func == bba_pkg::FUNC_FREE) begin
				scan_q <= AW'(blk_ext >> SH);
			end else begin
				scan_q <= AW'(lo_ext >> SH);
			end
		end else if (cmd.scan_adv) begin
			scan_q <= scan_q + AW'(1);
		end
		if (cmd.set_hit) begin
			res_id_q <= bba_pkg::ID_W'(found);
		end
		if (cmd.set_full) begin
			res_full_q <= 1'b1;
		end
		if (cmd.out_load) begin
			alloc_id <= res_id_q;
			status   <= res_full_q ? bba_pkg::STATUS_FULL : bba_pkg::STATUS_DONE;
		end
	end

	assign sts.is_free  = (func_q == bba_pkg::FUNC_FREE);
	assign sts.empty    = empty_q;
	assign sts.hit      = hit;
	assign sts.at_last  = (scan_q == last_word);
	assign sts.in_map   = in_map_q;
	assign sts.clr_done = (clr_q == LAST_ROW);

	a_hit_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set_hit |-> (CW'(found) >= lo_q) && (CW'(found) < hi_q))
		else $error("allocated block outside the window");

	a_free_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_free |-> in_map_q && (func_q == bba_pkg::FUNC_FREE))
		else $error("map write for a block outside the map");

endmodule

// ----- design/bitmap_block_allocator.sv -----
// channel  role    handshake               payload
// cfg      write   cfg_we                  cfg_index, cfg_data
// req      input   req_valid / req_stall   func, block_id
// rsp      output  rsp_valid / rsp_stall   alloc_id, status
//
// Allocate: reads map words from the word of reserve_below up to the first with a free bit
// or the window's last word (none for an empty window, at most NUM_BLOCKS/MAP_WORD_BITS = 512).
// Free: read, modify, write back through the one map port.
// After reset a clearing pass zeroes every map word with req_stall high; configuration
// writes are taken meanwhile.
// A result waits in the output register while the next item runs; a second one holds in done.
module bitmap_block_allocator #(
	parameter int NUM_BLOCKS    = bba_pkg::NUM_BLOCKS_DEF,
	parameter int MAP_WORD_BITS = bba_pkg::MAP_WORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_index,
	input  logic [bba_pkg::CFG_W-1:0] cfg_data,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic                      func,
	input  logic [bba_pkg::ID_W-1:0]  block_id,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output logic [bba_pkg::ID_W-1:0]  alloc_id,
	output logic                      status
);

	logic [bba_pkg::CFG_W-1:0] total_blocks_q;
	logic [bba_pkg::CFG_W-1:0] reserve_below_q;
	bba_pkg::cmd_t             cmd;
	bba_pkg::sts_t             sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_blocks_q  <= bba_pkg::TOTAL_BLOCKS_RST;
			reserve_below_q <= bba_pkg::RESERVE_BELOW_RST;
		end else if (cfg_we) begin
			case (bba_pkg::cfg_reg_t'(cfg_index))
				bba_pkg::REG_TOTAL_BLOCKS:  total_blocks_q  <= cfg_data;
				bba_pkg::REG_RESERVE_BELOW: reserve_below_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bba_datapath #(
		.NUM_BLOCKS    (NUM_BLOCKS),
		.MAP_WORD_BITS (MAP_WORD_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.func          (func),
		.block_id      (block_id),
		.total_blocks  (total_blocks_q),
		.reserve_below (reserve_below_q),
		.alloc_id      (alloc_id),
		.status        (status)
	);

endmodule

// ----- test/bitmap_block_allocator_tb.sv -----
`timescale 1ns / 1ps

module bitmap_block_allocator_tb;

	localparam int NUM_BLOCKS   = bba_pkg::NUM_BLOCKS_DEF;
	localparam int CFG_W        = bba_pkg::CFG_W;
	localparam int ID_W         = bba_pkg::ID_W;
	localparam int RANDOM_ITEMS = 1150;
	localparam int CYCLE_LIMIT  = 4_000_000;

	typedef struct packed {
		logic [ID_W-1:0] alloc_id;
		logic            status;
	} alloc_result_t;

	class alloc_scoreboard;
		bit               in_use [NUM_BLOCKS];
		logic [CFG_W-1:0] total_blocks;
		logic [CFG_W-1:0] reserve_below;
		alloc_result_t    expected_q [$];
		logic [ID_W-1:0]  held_q [$];
		int               mismatches;

		function new();
			foreach (in_use[i]) in_use[i] = 1'b0;
			total_blocks  = bba_pkg::TOTAL_BLOCKS_RST;
			reserve_below = bba_pkg::RESERVE_BELOW_RST;
			mismatches    = 0;
		endfunction

		function void set_reg(bba_pkg::cfg_reg_t idx, logic [CFG_W-1:0] val);
			if (idx == bba_pkg::REG_TOTAL_BLOCKS)
				total_blocks = val;
			else
				reserve_below = val;
		endfunction

		// First fit over [reserve_below, min(total_blocks, NUM_BLOCKS)).
		function void note_item(bba_pkg::func_t f, logic [ID_W-1:0] id);
			alloc_result_t res;
			int unsigned   bound;
			int unsigned   i;
			res.alloc_id = '0;
			res.status   = bba_pkg::STATUS_DONE;
			if (f == bba_pkg::FUNC_FREE) begin
				in_use[id] = 1'b0;
				for (int k = 0; k < held_q.size(); k++) begin
					if (held_q[k] == id) begin
						held_q.delete(k);
						break;
					end
				end
			end else begin
				bound      = (total_blocks > NUM_BLOCKS) ? NUM_BLOCKS : total_blocks;
				res.status = bba_pkg::STATUS_FULL;
				for (i = reserve_below; i < bound; i++) begin
					if (!in_use[i]) begin
						in_use[i]    = 1'b1;
						res.alloc_id = ID_W'(i);
						res.status   = bba_pkg::STATUS_DONE;
						held_q.push_back(res.alloc_id);
						break;
					end
				end
			end
			expected_q.push_back(res);
		endfunction

		function void check_result(logic [ID_W-1:0] got_id, logic got_status);
			alloc_result_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result alloc_id %0d status %0d",
						$time, got_id, got_status);
				return;
			end
			want = expected_q.pop_front();
			if (want.alloc_id !== got_id || want.status !== got_status) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"%0t: mismatch: expected alloc_id %0d status %0d,",
						" got alloc_id %0d status %0d"},
						$time, want.alloc_id, want.status, got_id, got_status);
			end
		endfunction
	endclass

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [0:0]       cfg_index = '0;
	logic [CFG_W-1:0] cfg_data  = '0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	logic             func      = 1'b0;
	logic [ID_W-1:0]  block_id  = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	logic [ID_W-1:0]  alloc_id;
	logic             status;

	alloc_scoreboard sb;
	int              burst_left;
	int              stall_mode = 0;
	int              stall_span = 0;
	int              cycles     = 0;

	bitmap_block_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.func      (func),
		.block_id  (block_id),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.alloc_id  (alloc_id),
		.status    (status)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Hold the item until taken; keep valid high while the burst lasts.
	task automatic send_item(bba_pkg::func_t f, logic [ID_W-1:0] id);
		req_valid <= 1'b1;
		func      <= f;
		block_id  <= id;
		do @(posedge clk); while (req_stall);
		sb.note_item(f, id);
		burst_left--;
		if (burst_left <= 0) begin
			req_valid <= 1'b0;
			repeat (($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6))
				@(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
	endtask

	// Drain every outstanding result, then write both registers.
	task automatic reconfigure(logic [CFG_W-1:0] total, logic [CFG_W-1:0] reserve);
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_q.size() != 0);
		cfg_we    <= 1'b1;
		cfg_index <= bba_pkg::REG_TOTAL_BLOCKS;
		cfg_data  <= total;
		@(posedge clk);
		cfg_index <= bba_pkg::REG_RESERVE_BELOW;
		cfg_data  <= reserve;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_reg(bba_pkg::REG_TOTAL_BLOCKS, total);
		sb.set_reg(bba_pkg::REG_RESERVE_BELOW, reserve);
	endtask

	initial begin
		int unsigned      sent;
		int unsigned      pick;
		logic [CFG_W-1:0] next_total;
		logic [CFG_W-1:0] next_reserve;
		sb = new();
		burst_left = $urandom_range(1, 12);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: allocation starts at the reserve boundary
		send_item(bba_pkg::FUNC_ALLOC, '0);
		send_item(bba_pkg::FUNC_ALLOC, '0);
		send_item(bba_pkg::FUNC_FREE, ID_W'(4096));
		send_item(bba_pkg::FUNC_ALLOC, '0);
		send_item(bba_pkg::FUNC_FREE, ID_W'(4097));
		send_item(bba_pkg::FUNC_FREE, ID_W'(4097));
		send_item(bba_pkg::FUNC_FREE, '0);
		send_item(bba_pkg::FUNC_FREE, '1);
		send_item(bba_pkg::FUNC_FREE, ID_W'(15'h5555));
		send_item(bba_pkg::FUNC_FREE, ID_W'(15'h2AAA));
		send_item(bba_pkg::FUNC_ALLOC, '1);
		// empty range
		reconfigure(16'd0, 16'd4096);
		send_item(bba_pkg::FUNC_ALLOC, '0);
		// bound beyond the map, only the top block left
		reconfigure(16'hFFFF, 16'd32767);
		send_item(bba_pkg::FUNC_ALLOC, '0);
		send_item(bba_pkg::FUNC_ALLOC, '0);
		send_item(bba_pkg::FUNC_FREE, '1);
		send_item(bba_pkg::FUNC_ALLOC, '0);
		// single block at the bottom
		reconfigure(16'd1, 16'd0);
		send_item(bba_pkg::FUNC_ALLOC, '0);
		send_item(bba_pkg::FUNC_ALLOC, '0);
		send_item(bba_pkg::FUNC_FREE, '0);
		reconfigure(16'd32768, 16'd32768);
		send_item(bba_pkg::FUNC_ALLOC, '0);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 11))
				0: begin
					next_total   = 16'hFFFF;
					next_reserve = 16'd32768 - CFG_W'($urandom_range(1, 100));
				end
				1: begin
					next_total   = CFG_W'($urandom_range(1, 200));
					next_reserve = 16'd0;
				end
				2: begin
					next_total   = CFG_W'($urandom_range(0, 65535));
					next_reserve = 16'd32768;
				end
				3: begin
					next_total   = 16'd0;
					next_reserve = CFG_W'($urandom_range(0, 32768));
				end
				4: begin
					next_reserve = CFG_W'($urandom_range(100, 32767));
					next_total   = next_reserve - CFG_W'($urandom_range(0, 50));
				end
				default: begin
					next_reserve = CFG_W'($urandom_range(0, 32767));
					next_total   = next_reserve + CFG_W'(($urandom_range(0, 3) == 0)
						? $urandom_range(150, 1500) : $urandom_range(1, 150));
				end
			endcase
			reconfigure(next_total, next_reserve);
			repeat ($urandom_range(50, 120)) begin
				if (sent >= RANDOM_ITEMS)
					break;
				pick = $urandom_range(0, 99);
				if (pick < 55 || sb.held_q.size() == 0)
					send_item(bba_pkg::FUNC_ALLOC, ID_W'($urandom));
				else if (pick < 90)
					send_item(bba_pkg::FUNC_FREE,
						sb.held_q[$urandom_range(0, sb.held_q.size() - 1)]);
				else
					send_item(bba_pkg::FUNC_FREE, ID_W'($urandom));
				sent++;
			end
		end

		req_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_q.size() != 0);
		repeat (600) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Take results and stall on stretches of varying density.
	always @(posedge clk) begin
		if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
			sb.check_result(alloc_id, status);
		if (stall_span == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_span <= $urandom_range(10, 200);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= ($urandom_range(0, 3) == 0);
			default: rsp_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

endmodule

// ----- files.f -----
design/bba_pkg.sv
design/bba_ctrl.sv
design/bba_datapath.sv
design/bitmap_block_allocator.sv
test/bitmap_block_allocator_tb.sv
